>>> src/cca_pkg.sv
`default_nettype none

package cca_pkg;

	localparam int CLUSTERS = 256;
	localparam int AW = $clog2(CLUSTERS);  // cluster index bits
	localparam int CW = 9;                 // count field bits
	localparam int LW = AW + 1;            // link entry bits: index plus end mark

	localparam logic [LW-1:0] LINK_FREE = '0;
	localparam logic [LW-1:0] LINK_EOC = {1'b1, {AW{1'b0}}};
	localparam logic [AW-1:0] FREE_ALL = AW'(CLUSTERS - 1);  // cluster 0 never counts

	typedef enum logic [2:0] {
		K_FORMAT = 3'd0,
		K_ALLOC  = 3'd1,
		K_EXTEND = 3'd2,
		K_FREE   = 3'd3,
		K_LENGTH = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	// next probe address
	typedef enum logic [2:0] {
		X_HOLD = 3'd0,
		X_HEAD = 3'd1,
		X_LINK = 3'd2,
		X_ONE  = 3'd3,
		X_INC  = 3'd4
	} xsel_t;

	// table write
	typedef enum logic [2:0] {
		W_NONE = 3'd0,
		W_CLR  = 3'd1,
		W_LINK = 3'd2,
		W_EOC  = 3'd3,
		W_TAIL = 3'd4
	} wsel_t;

	// how the result word is built
	typedef enum logic [1:0] {
		RM_NONE = 2'd0,
		RM_CNT  = 2'd1,
		RM_ECHO = 2'd2,
		RM_TAKE = 2'd3
	} rmode_t;

	typedef struct packed {
		logic    load;
		xsel_t   xsel;
		wsel_t   wsel;
		logic    walk_init;
		logic    walk_step;
		logic    take_init;
		logic    take_hit;
		logic    fmt;
		logic    res_load;
		status_t res_st;
		rmode_t  res_mode;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       hv;
		logic       head_zero;
		logic       n_zero;
		logic       short_space;
		logic       v_zero;
		logic       v_eoc;
		logic       cnt_zero;
		logic       cnt_last;
		logic       got_zero;
		logic       got_last;
	} sts_t;

endpackage

`default_nettype wire

>>> src/cca_if.sv
`default_nettype none

interface cca_req_if;
	logic                    valid;
	logic                    ready;
	logic [2:0]              kind;
	logic [cca_pkg::AW-1:0]  head_cluster;
	logic                    head_valid;
	logic [cca_pkg::CW-1:0]  alloc_clusters;

	modport source (output valid, kind, head_cluster, head_valid, alloc_clusters, input ready);
	modport sink (input valid, kind, head_cluster, head_valid, alloc_clusters, output ready);
endinterface

interface cca_rsp_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [cca_pkg::AW-1:0]  head_out;
	logic                    head_out_valid;
	logic [cca_pkg::CW-1:0]  chain_clusters;

	modport source (output valid, status, head_out, head_out_valid, chain_clusters, input ready);
	modport sink (input valid, status, head_out, head_out_valid, chain_clusters, output ready);
endinterface

`default_nettype wire

>>> src/cca_dp.sv
`default_nettype none

module cca_dp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [2:0]             kind,
	input  wire logic [cca_pkg::AW-1:0] head_cluster,
	input  wire logic                   head_valid,
	input  wire logic [cca_pkg::CW-1:0] alloc_clusters,
	input  wire cca_pkg::cmd_t          cmd,
	output cca_pkg::sts_t               sts,
	output logic [1:0]                  status,
	output logic [cca_pkg::AW-1:0]      head_out,
	output logic                        head_out_valid,
	output logic [cca_pkg::CW-1:0]      chain_clusters
);

	// latched request
	logic [2:0]              kind_q;
	logic [cca_pkg::AW-1:0]  head_q;
	logic                    hv_q;
	logic [cca_pkg::CW-1:0]  n_q;

	// walk / scan state
	logic [cca_pkg::AW-1:0]  x_q;
	logic [cca_pkg::AW-1:0]  x_d;
	logic [cca_pkg::AW-1:0]  tail_q;
	logic [cca_pkg::AW-1:0]  first_q;
	logic [cca_pkg::AW-1:0]  prev_q;
	logic [cca_pkg::AW-1:0]  free_q;
	logic [cca_pkg::CW-1:0]  cnt_q;
	logic [cca_pkg::CW-1:0]  got_q;

	// link table
	logic [cca_pkg::LW-1:0]  mem [cca_pkg::CLUSTERS];
	logic [cca_pkg::CLUSTERS-1:0] vld_q;
	logic [cca_pkg::LW-1:0]  mem_rd_q;
	logic [cca_pkg::LW-1:0]  fwd_q;
	logic                    vld_rd_q;
	logic                    fwd_hit_q;
	logic [cca_pkg::LW-1:0]  rd;
	logic                    we;
	logic [cca_pkg::AW-1:0]  waddr;
	logic [cca_pkg::LW-1:0]  wdata;

	// result word
	cca_pkg::status_t        status_q;
	logic [cca_pkg::AW-1:0]  head_out_q;
	logic                    hov_q;
	logic [cca_pkg::CW-1:0]  cc_q;

	always_comb begin
		unique case (cmd.xsel)
			cca_pkg::X_HOLD: x_d = x_q;
			cca_pkg::X_HEAD: x_d = head_q;
			cca_pkg::X_LINK: x_d = rd[cca_pkg::AW-1:0];
			cca_pkg::X_ONE:  x_d = cca_pkg::AW'(1);
			cca_pkg::X_INC:  x_d = x_q + cca_pkg::AW'(1);
			default:         x_d = x_q;
		endcase
	end

	always_comb begin
		we = 1'b1;
		waddr = x_q;
		wdata = cca_pkg::LINK_FREE;
		unique case (cmd.wsel)
			cca_pkg::W_CLR: begin
				waddr = x_q;
				wdata = cca_pkg::LINK_FREE;
			end
			cca_pkg::W_LINK: begin
				waddr = prev_q;
				wdata = {1'b0, x_q};
			end
			cca_pkg::W_EOC: begin
				waddr = prev_q;
				wdata = cca_pkg::LINK_EOC;
			end
			cca_pkg::W_TAIL: begin
				waddr = tail_q;
				wdata = {1'b0, first_q};
			end
			default: we = 1'b0;
		endcase
	end

	// a write to the address read in the same cycle is passed through
	assign rd = fwd_hit_q ? fwd_q : (vld_rd_q ? mem_rd_q : cca_pkg::LINK_FREE);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_rd_q <= mem[x_d];
		fwd_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_rd_q <= 1'b0;
			fwd_hit_q <= 1'b0;
			free_q <= cca_pkg::FREE_ALL;
		end else begin
			if (cmd.fmt) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			vld_rd_q <= vld_q[x_d];
			fwd_hit_q <= we && (waddr == x_d);
			if (cmd.fmt) begin
				free_q <= cca_pkg::FREE_ALL;
			end else if (cmd.walk_step && cmd.wsel == cca_pkg::W_CLR) begin
				free_q <= free_q + cca_pkg::AW'(1);
			end else if (cmd.take_hit) begin
				free_q <= free_q - cca_pkg::AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			head_q <= head_cluster;
			hv_q <= head_valid;
			n_q <= alloc_clusters;
		end
		x_q <= x_d;
		if (cmd.walk_init) begin
			cnt_q <= '0;
		end else if (cmd.walk_step) begin
			cnt_q <= cnt_q + cca_pkg::CW'(1);
			tail_q <= x_q;
		end
		if (cmd.take_init) begin
			got_q <= '0;
		end else if (cmd.take_hit) begin
			if (got_q == '0) begin
				first_q <= x_q;
			end
			prev_q <= x_q;
			got_q <= got_q + cca_pkg::CW'(1);
		end
		if (cmd.res_load) begin
			status_q <= cmd.res_st;
			case (cmd.res_mode)
				cca_pkg::RM_CNT: begin
					head_out_q <= '0;
					hov_q <= 1'b0;
					cc_q <= cnt_q;
				end
				cca_pkg::RM_ECHO: begin
					head_out_q <= hv_q ? head_q : '0;
					hov_q <= hv_q;
					cc_q <= '0;
				end
				cca_pkg::RM_TAKE: begin
					head_out_q <= (kind_q == cca_pkg::K_EXTEND && hv_q) ? head_q : first_q;
					hov_q <= 1'b1;
					cc_q <= n_q;
				end
				default: begin
					head_out_q <= '0;
					hov_q <= 1'b0;
					cc_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		sts.kind = kind_q;
		sts.hv = hv_q;
		sts.head_zero = (head_q == '0);
		sts.n_zero = (n_q == '0);
		sts.short_space = ({1'b0, free_q} < n_q);
		sts.v_zero = (rd == cca_pkg::LINK_FREE);
		sts.v_eoc = rd[cca_pkg::AW];
		sts.cnt_zero = (cnt_q == '0);
		sts.cnt_last = (cnt_q == cca_pkg::CW'(cca_pkg::CLUSTERS - 1));
		sts.got_zero = (got_q == '0);
		sts.got_last = ((got_q + cca_pkg::CW'(1)) == n_q);
	end

	assign status = status_q;
	assign head_out = head_out_q;
	assign head_out_valid = hov_q;
	assign chain_clusters = cc_q;

	a_take_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_hit |-> free_q != '0)
		else $error("take with no free cluster");

	a_links_ascend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wsel == cca_pkg::W_LINK |-> prev_q < x_q)
		else $error("new link does not ascend");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> cnt_q < cca_pkg::CW'(cca_pkg::CLUSTERS))
		else $error("walk past cluster count");

endmodule

`default_nettype wire

>>> src/cca_ctrl.sv
`default_nettype none

module cca_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire cca_pkg::sts_t sts,
	output cca_pkg::cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DEC  = 7'b0000010,
		S_WALK = 7'b0000100,
		S_TAKE = 7'b0001000,
		S_EOC  = 7'b0010000,
		S_LINK = 7'b0100000,
		S_RESP = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	cca_pkg::status_t  st_q, st_d;
	cca_pkg::rmode_t   mode_q, mode_d;
	logic              out_vld_q;

	logic              fin;
	cca_pkg::status_t  fin_st;
	cca_pkg::rmode_t   fin_mode;
	logic              go_take;
	logic              go_walk;
	logic              walk_end;

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		mode_d = mode_q;
		cmd = '0;
		fin = 1'b0;
		fin_st = cca_pkg::ST_OK;
		fin_mode = cca_pkg::RM_NONE;
		go_take = 1'b0;
		go_walk = 1'b0;
		walk_end = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (sts.kind) inside
					cca_pkg::K_FORMAT: begin
						cmd.fmt = 1'b1;
						fin = 1'b1;
					end
					cca_pkg::K_ALLOC: begin
						if (sts.n_zero) begin
							fin = 1'b1;
							fin_st = cca_pkg::ST_BAD;
						end else if (sts.short_space) begin
							fin = 1'b1;
							fin_st = cca_pkg::ST_FULL;
						end else begin
							go_take = 1'b1;
						end
					end
					cca_pkg::K_EXTEND: begin
						if (sts.hv) begin
							if (sts.head_zero) begin
								fin = 1'b1;
								fin_st = cca_pkg::ST_BAD;
							end else begin
								go_walk = 1'b1;
							end
						end else if (sts.n_zero) begin
							fin = 1'b1;
							fin_mode = cca_pkg::RM_ECHO;
						end else if (sts.short_space) begin
							fin = 1'b1;
							fin_st = cca_pkg::ST_FULL;
						end else begin
							go_take = 1'b1;
						end
					end
					cca_pkg::K_FREE, cca_pkg::K_LENGTH: begin
						if (!sts.hv) begin
							fin = 1'b1;
						end else if (sts.head_zero) begin
							fin = 1'b1;
							fin_st = cca_pkg::ST_BAD;
						end else begin
							go_walk = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
						fin_st = cca_pkg::ST_BAD;
					end
				endcase
			end
			S_WALK: begin
				if (sts.v_zero) begin
					if (sts.cnt_zero) begin
						fin = 1'b1;
						fin_st = cca_pkg::ST_BAD;
					end else begin
						walk_end = 1'b1;
					end
				end else begin
					cmd.walk_step = 1'b1;
					if (sts.kind == cca_pkg::K_FREE) begin
						cmd.wsel = cca_pkg::W_CLR;
					end
					if (sts.v_eoc || sts.cnt_last) begin
						walk_end = 1'b1;
					end else begin
						cmd.xsel = cca_pkg::X_LINK;
					end
				end
				if (walk_end) begin
					if (sts.kind != cca_pkg::K_EXTEND) begin
						fin = 1'b1;
						fin_mode = cca_pkg::RM_CNT;
					end else if (sts.n_zero) begin
						fin = 1'b1;
						fin_mode = cca_pkg::RM_ECHO;
					end else if (sts.short_space) begin
						fin = 1'b1;
						fin_st = cca_pkg::ST_FULL;
					end else begin
						go_take = 1'b1;
					end
				end
			end
			S_TAKE: begin
				cmd.xsel = cca_pkg::X_INC;
				if (sts.v_zero) begin
					cmd.take_hit = 1'b1;
					if (!sts.got_zero) begin
						cmd.wsel = cca_pkg::W_LINK;
					end
					if (sts.got_last) begin
						cmd.xsel = cca_pkg::X_HOLD;
						state_d = S_EOC;
					end
				end
			end
			S_EOC: begin
				cmd.wsel = cca_pkg::W_EOC;
				if (sts.kind == cca_pkg::K_EXTEND && sts.hv) begin
					state_d = S_LINK;
				end else begin
					fin = 1'b1;
					fin_mode = cca_pkg::RM_TAKE;
				end
			end
			S_LINK: begin
				cmd.wsel = cca_pkg::W_TAIL;
				fin = 1'b1;
				fin_mode = cca_pkg::RM_TAKE;
			end
			S_RESP: begin
				if (!out_vld_q || out_ready) begin
					cmd.res_load = 1'b1;
					cmd.res_st = st_q;
					cmd.res_mode = mode_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (go_walk) begin
			cmd.walk_init = 1'b1;
			cmd.xsel = cca_pkg::X_HEAD;
			state_d = S_WALK;
		end
		if (go_take) begin
			cmd.take_init = 1'b1;
			cmd.xsel = cca_pkg::X_ONE;
			state_d = S_TAKE;
		end
		if (fin) begin
			state_d = S_RESP;
			st_d = fin_st;
			mode_d = fin_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= cca_pkg::ST_OK;
			mode_q <= cca_pkg::RM_NONE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
			mode_q <= mode_d;
			if (cmd.res_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_vld_q || out_ready))
		else $error("result word overwritten before it was taken");

	a_eoc_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EOC |-> $past(cmd.take_hit && sts.got_last))
		else $error("end mark without last cluster taken");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DEC)
		else $error("accepted word not decoded");

endmodule

`default_nettype wire

>>> src/cluster_chain_allocator.sv
`default_nettype none

// Channel  Dir  Word fields
// -------  ---  -----------------------------------------------------
// req      in   kind[2:0] head_cluster[7:0] head_valid alloc_clusters[8:0]
// rsp      out  status[1:0] head_out[7:0] head_out_valid chain_clusters[8:0]
//
// One request at a time: decode, a walk of the chain a cluster at a time,
// a scan of the entries while taking, then end mark, tail link and response load.
// The slowest request is an extend of a long chain.
// Reset and format clear the table at once through per-entry valid flags.
// The next word is accepted while a response waits; its result holds on it.

module cluster_chain_allocator (
	input  wire logic clk,
	input  wire logic arst_n,
	cca_req_if.sink   req,
	cca_rsp_if.source rsp
);

	cca_pkg::cmd_t cmd;
	cca_pkg::sts_t sts;

	// sequencer: decode, walk, take, link, respond
	cca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// link table, free counter, chain pointers and the response register
	cca_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (req.kind),
		.head_cluster   (req.head_cluster),
		.head_valid     (req.head_valid),
		.alloc_clusters (req.alloc_clusters),
		.cmd            (cmd),
		.sts            (sts),
		.status         (rsp.status),
		.head_out       (rsp.head_out),
		.head_out_valid (rsp.head_out_valid),
		.chain_clusters (rsp.chain_clusters)
	);

endmodule

`default_nettype wire
